// ===== hw/rtl/rainbow_hsv_to_rgb_pwm_macros.svh =====
// Assertion macros for the rainbow HSV to RGB PWM block
`ifndef RAINBOW_HSV_TO_RGB_PWM_MACROS_SVH
`define RAINBOW_HSV_TO_RGB_PWM_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define RHSV_ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RHSV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rhsv_pkg.sv =====
// Package: types and constants of the rainbow HSV to RGB PWM block
`default_nettype none

package rhsv_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned TICKS_W   = 4;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CMP_W     = 10;
  localparam int unsigned MUL_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [TICK_W-1:0] PERIOD_RST  = 16'd100;
  localparam logic [PCT_W-1:0]  SAT_RST     = 7'd100;
  localparam logic [PCT_W-1:0]  BRI_RST     = 7'd20;
  localparam logic [HUE_W-1:0]  STEP_RST    = 9'd5;
  localparam logic [TICK_W-1:0] TICK_SAT    = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PERCENT_FULL = 7'd100;
  localparam logic [HUE_W:0]    HUE_WRAP    = 10'd360;

  localparam logic [MUL_W-1:0]  CHANNEL_FULL = 15'd255;
  localparam logic [MUL_W-1:0]  SECTOR_DEG   = 15'd60;
  // x/100 = (x*5243)>>19, exact for x below 43690
  // x/60 = (x*17477)>>20, exact for x below 23831
  localparam logic [MUL_W-1:0]  RECIP_100    = 15'd5243;
  localparam int unsigned       SHIFT_100    = 19;
  localparam logic [MUL_W-1:0]  RECIP_60     = 15'd17477;
  localparam int unsigned       SHIFT_60     = 20;
  localparam int unsigned       COMPARE_SHIFT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPDATE_PERIOD = 2'd0,
    REG_SATURATION    = 2'd1,
    REG_BRIGHTNESS    = 2'd2,
    REG_HUE_STEP      = 2'd3
  } rhsv_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HI_MUL,
    ST_HI_DIV,
    ST_LO_MUL,
    ST_LO_DIV,
    ST_SEC_DIV,
    ST_SEC_MUL,
    ST_ADJ_MUL,
    ST_ADJ_DIV,
    ST_DONE
  } rhsv_state_e;

  typedef enum logic [2:0] {
    SEC_RED_TO_YELLOW     = 3'd0,
    SEC_YELLOW_TO_GREEN   = 3'd1,
    SEC_GREEN_TO_CYAN     = 3'd2,
    SEC_CYAN_TO_BLUE      = 3'd3,
    SEC_BLUE_TO_MAGENTA   = 3'd4,
    SEC_MAGENTA_TO_RED    = 3'd5
  } rhsv_sector_e;

  typedef struct packed {
    logic              start;
    logic              ack;
    logic [HUE_W-1:0]  hue;
    logic [PCT_W-1:0]  sat;
    logic [PCT_W-1:0]  bri;
  } rhsv_req_t;

  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [HUE_W-1:0]  hue;
  } rhsv_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rhsv_core.sv =====
// Iterative HSV to RGB converter built around one shared multiplier
`default_nettype none

module rhsv_core
  import rhsv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rhsv_req_t req_i,
  output rhsv_rsp_t      rsp_o
);

  rhsv_state_e state_q, state_d;

  logic [HUE_W-1:0]  hue_q, hue_d;
  logic [PCT_W-1:0]  sat_q, sat_d;
  logic [PCT_W-1:0]  bri_q, bri_d;
  logic [MUL_W-1:0]  tmp_q, tmp_d;
  logic [CHAN_W-1:0] hi_q, hi_d;
  logic [CHAN_W-1:0] lo_q, lo_d;
  logic [CHAN_W-1:0] adj_q, adj_d;
  logic [2:0]        sec_q, sec_d;
  logic [5:0]        rem_q, rem_d;

  logic [MUL_W-1:0]   mul_a_s, mul_b_s;
  logic [2*MUL_W-1:0] prod_s;
  logic [HUE_W-1:0]   rem_full_s;
  rhsv_sector_e       sector_s;
  logic [CHAN_W-1:0]  up_s, down_s;

  assign prod_s     = (2*MUL_W)'(mul_a_s) * (2*MUL_W)'(mul_b_s);
  assign rem_full_s = hue_q - prod_s[HUE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    sat_q <= sat_d;
    bri_q <= bri_d;
    tmp_q <= tmp_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    adj_q <= adj_d;
    sec_q <= sec_d;
    rem_q <= rem_d;
  end

  always_comb begin
    state_d = state_q;
    hue_d   = hue_q;
    sat_d   = sat_q;
    bri_d   = bri_q;
    tmp_d   = tmp_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    adj_d   = adj_q;
    sec_d   = sec_q;
    rem_d   = rem_q;
    mul_a_s = '0;
    mul_b_s = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          hue_d   = req_i.hue;
          sat_d   = (req_i.sat > PERCENT_FULL) ? PERCENT_FULL : req_i.sat;
          bri_d   = (req_i.bri > PERCENT_FULL) ? PERCENT_FULL : req_i.bri;
          state_d = ST_HI_MUL;
        end
      end
      ST_HI_MUL: begin
        mul_a_s = MUL_W'(bri_q);
        mul_b_s = CHANNEL_FULL;
        tmp_d   = prod_s[MUL_W-1:0];
        state_d = ST_HI_DIV;
      end
      ST_HI_DIV: begin
        mul_a_s = tmp_q;
        mul_b_s = RECIP_100;
        hi_d    = prod_s[SHIFT_100 +: CHAN_W];
        state_d = ST_LO_MUL;
      end
      ST_LO_MUL: begin
        mul_a_s = MUL_W'(hi_q);
        mul_b_s = MUL_W'(PERCENT_FULL - sat_q);
        tmp_d   = prod_s[MUL_W-1:0];
        state_d = ST_LO_DIV;
      end
      ST_LO_DIV: begin
        mul_a_s = tmp_q;
        mul_b_s = RECIP_100;
        lo_d    = prod_s[SHIFT_100 +: CHAN_W];
        state_d = ST_SEC_DIV;
      end
      ST_SEC_DIV: begin
        mul_a_s = MUL_W'(hue_q);
        mul_b_s = RECIP_60;
        sec_d   = prod_s[SHIFT_60 +: 3];
        state_d = ST_SEC_MUL;
      end
      ST_SEC_MUL: begin
        mul_a_s = MUL_W'(sec_q);
        mul_b_s = SECTOR_DEG;
        rem_d   = rem_full_s[5:0];
        state_d = ST_ADJ_MUL;
      end
      ST_ADJ_MUL: begin
        mul_a_s = MUL_W'(hi_q - lo_q);
        mul_b_s = MUL_W'(rem_q);
        tmp_d   = prod_s[MUL_W-1:0];
        state_d = ST_ADJ_DIV;
      end
      ST_ADJ_DIV: begin
        mul_a_s = tmp_q;
        mul_b_s = RECIP_60;
        adj_d   = prod_s[SHIFT_60 +: CHAN_W];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (req_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign sector_s = rhsv_sector_e'(sec_q);
  assign up_s     = lo_q + adj_q;
  assign down_s   = hi_q - adj_q;

  always_comb begin
    rsp_o.done = (state_q == ST_DONE);
    rsp_o.hue  = hue_q;
    unique case (sector_s)
      SEC_RED_TO_YELLOW: begin
        rsp_o.red = hi_q;   rsp_o.green = up_s;   rsp_o.blue = lo_q;
      end
      SEC_YELLOW_TO_GREEN: begin
        rsp_o.red = down_s; rsp_o.green = hi_q;   rsp_o.blue = lo_q;
      end
      SEC_GREEN_TO_CYAN: begin
        rsp_o.red = lo_q;   rsp_o.green = hi_q;   rsp_o.blue = up_s;
      end
      SEC_CYAN_TO_BLUE: begin
        rsp_o.red = lo_q;   rsp_o.green = down_s; rsp_o.blue = hi_q;
      end
      SEC_BLUE_TO_MAGENTA: begin
        rsp_o.red = up_s;   rsp_o.green = lo_q;   rsp_o.blue = hi_q;
      end
      default: begin
        rsp_o.red = hi_q;   rsp_o.green = lo_q;   rsp_o.blue = down_s;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rainbow_hsv_to_rgb_pwm.sv =====
// Top level: rainbow color stepper producing PWM compare values from HSV
//
// Input channel (in_valid_i/in_ready_o) carries ticks_elapsed. Each transaction
// adds its ticks to a 16-bit saturating counter. When the counter reaches
// update_period, it clears and one result transaction follows on the output
// channel (out_valid_o/out_ready_i) with the RGB compare values and the hue;
// the hue then advances by hue_step and returns to 0 at 360 or above.
// A transaction that does not reach the period gives no result, and the
// block is ready again in the next cycle.
// A due transaction runs eight steps of one shared 15x15 multiplier: when the
// result is presented, in_ready_o returns in the same cycle, so the block takes
// no new transaction while a due one is converted. The output register lets
// the block take the next transaction while a result waits; a new result
// waits in the converter until the receiver takes the old one, holding
// in_ready_o low. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_wdata_i); the user must write it while idle, which the block does not
// enforce. Reset restores the register defaults (period 100, saturation 100,
// brightness 20, step 5) and clears counter, hue and out_valid_o.
`default_nettype none

module rainbow_hsv_to_rgb_pwm
  import rhsv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TICKS_W-1:0]   ticks_elapsed_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CMP_W-1:0]          red_compare_o,
  output logic [CMP_W-1:0]          green_compare_o,
  output logic [CMP_W-1:0]          blue_compare_o,
  output logic [HUE_W-1:0]          hue_used_o
);

  logic [TICK_W-1:0] period_q;
  logic [PCT_W-1:0]  sat_q;
  logic [PCT_W-1:0]  bri_q;
  logic [HUE_W-1:0]  step_q;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [HUE_W-1:0]  hue_q, hue_d;
  logic              busy_q, busy_d;
  logic              out_valid_q, out_valid_d;
  logic [CMP_W-1:0]  red_q, green_q, blue_q;
  logic [HUE_W-1:0]  hue_used_q;

  logic              in_fire_s;
  logic [TICK_W:0]   tick_sum_s;
  logic [TICK_W-1:0] tick_sat_s;
  logic              due_s;
  logic              load_s;
  logic [HUE_W:0]    hue_next_s;
  rhsv_req_t         req_s;
  rhsv_rsp_t         rsp_s;

  rhsv_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_s),
    .rsp_o  (rsp_s)
  );

  assign in_ready_o = !busy_q;
  assign in_fire_s  = in_valid_i && in_ready_o;
  assign tick_sum_s = {1'b0, tick_q} + (TICK_W+1)'(ticks_elapsed_i);
  assign tick_sat_s = tick_sum_s[TICK_W] ? TICK_SAT : tick_sum_s[TICK_W-1:0];
  assign due_s      = (tick_sat_s >= period_q);
  assign load_s     = rsp_s.done && (!out_valid_q || out_ready_i);
  assign hue_next_s = {1'b0, hue_q} + {1'b0, step_q};

  assign req_s.start = in_fire_s && due_s;
  assign req_s.ack   = load_s;
  assign req_s.hue   = hue_q;
  assign req_s.sat   = sat_q;
  assign req_s.bri   = bri_q;

  always_comb begin
    tick_d      = tick_q;
    hue_d       = hue_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire_s) begin
      tick_d = due_s ? '0 : tick_sat_s;
      busy_d = due_s;
    end
    if (load_s) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
      hue_d       = (hue_next_s >= HUE_WRAP) ? '0 : hue_next_s[HUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      sat_q       <= SAT_RST;
      bri_q       <= BRI_RST;
      step_q      <= STEP_RST;
      tick_q      <= '0;
      hue_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      hue_q       <= hue_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (rhsv_reg_e'(cfg_index_i))
          REG_UPDATE_PERIOD: period_q <= cfg_wdata_i;
          REG_SATURATION:    sat_q    <= cfg_wdata_i[PCT_W-1:0];
          REG_BRIGHTNESS:    bri_q    <= cfg_wdata_i[PCT_W-1:0];
          REG_HUE_STEP:      step_q   <= cfg_wdata_i[HUE_W-1:0];
          default:           period_q <= period_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s) begin
      red_q      <= {rsp_s.red,   COMPARE_SHIFT'(0)};
      green_q    <= {rsp_s.green, COMPARE_SHIFT'(0)};
      blue_q     <= {rsp_s.blue,  COMPARE_SHIFT'(0)};
      hue_used_q <= rsp_s.hue;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_compare_o   = red_q;
  assign green_compare_o = green_q;
  assign blue_compare_o  = blue_q;
  assign hue_used_o      = hue_used_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rhsv_checker.sv =====
// Port checker for the rainbow HSV to RGB PWM block, bound to the top level
`default_nettype none
`include "rainbow_hsv_to_rgb_pwm_macros.svh"

module rhsv_checker
  import rhsv_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [CMP_W-1:0]  red_compare_o,
  input wire logic [CMP_W-1:0]  green_compare_o,
  input wire logic [CMP_W-1:0]  blue_compare_o,
  input wire logic [HUE_W-1:0]  hue_used_o
);

  `RHSV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `RHSV_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(red_compare_o) && $stable(green_compare_o) && $stable(blue_compare_o) && $stable(hue_used_o), "result changed while stalled")
  `RHSV_ASSERT_ALWAYS(a_hue_range, clk_i, rst_ni, !out_valid_o || (hue_used_o < HUE_W'(HUE_WRAP)), "hue_used out of range")
  `RHSV_ASSERT_ALWAYS(a_cmp_aligned, clk_i, rst_ni, !out_valid_o || ((red_compare_o[1:0] == 2'd0) && (green_compare_o[1:0] == 2'd0) && (blue_compare_o[1:0] == 2'd0)), "compare value not a channel times four")

endmodule

bind rainbow_hsv_to_rgb_pwm rhsv_checker u_rhsv_checker (.*);

`default_nettype wire

// ===== bench/tb_rainbow_hsv_to_rgb_pwm.sv =====
// Testbench for rainbow_hsv_to_rgb_pwm: tick streams checked against a color predictor
module tb_rainbow_hsv_to_rgb_pwm;
  import rhsv_pkg::*;

  typedef struct {
    logic [CMP_W-1:0] red;
    logic [CMP_W-1:0] green;
    logic [CMP_W-1:0] blue;
    logic [HUE_W-1:0] hue;
  } color_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [TICKS_W-1:0]   ticks_elapsed_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [CMP_W-1:0]     red_compare_o;
  logic [CMP_W-1:0]     green_compare_o;
  logic [CMP_W-1:0]     blue_compare_o;
  logic [HUE_W-1:0]     hue_used_o;

  color_t            expected_colors[$];
  logic [TICK_W-1:0] period_cfg;
  logic [PCT_W-1:0]  sat_cfg;
  logic [PCT_W-1:0]  bri_cfg;
  logic [HUE_W-1:0]  step_cfg;
  logic [HUE_W-1:0]  hue_now;
  logic [TICK_W-1:0] tick_total;
  int                errors;
  bit                calm;

  rainbow_hsv_to_rgb_pwm u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ticks_elapsed_i (ticks_elapsed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_compare_o   (red_compare_o),
    .green_compare_o (green_compare_o),
    .blue_compare_o  (blue_compare_o),
    .hue_used_o      (hue_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic color_t paint_hue(input logic [HUE_W-1:0] h);
    int unsigned  s;
    int unsigned  v;
    int unsigned  hi;
    int unsigned  lo;
    int unsigned  adj;
    int unsigned  r;
    int unsigned  g;
    int unsigned  b;
    rhsv_sector_e sec;
    color_t       c;
    s   = (sat_cfg > 100) ? 100 : sat_cfg;
    v   = (bri_cfg > 100) ? 100 : bri_cfg;
    hi  = v * 255 / 100;
    lo  = hi * (100 - s) / 100;
    adj = (hi - lo) * (h % 60) / 60;
    sec = rhsv_sector_e'(h / 60);
    case (sec)
      SEC_RED_TO_YELLOW: begin
        r = hi; g = lo + adj; b = lo;
      end
      SEC_YELLOW_TO_GREEN: begin
        r = hi - adj; g = hi; b = lo;
      end
      SEC_GREEN_TO_CYAN: begin
        r = lo; g = hi; b = lo + adj;
      end
      SEC_CYAN_TO_BLUE: begin
        r = lo; g = hi - adj; b = hi;
      end
      SEC_BLUE_TO_MAGENTA: begin
        r = lo + adj; g = lo; b = hi;
      end
      default: begin
        r = hi; g = lo; b = hi - adj;
      end
    endcase
    c.red   = CMP_W'(r << COMPARE_SHIFT);
    c.green = CMP_W'(g << COMPARE_SHIFT);
    c.blue  = CMP_W'(b << COMPARE_SHIFT);
    c.hue   = h;
    return c;
  endfunction

  function automatic void advance_rainbow(input logic [TICKS_W-1:0] ticks);
    logic [TICK_W:0]  sum;
    logic [HUE_W:0]   nxt;
    logic [HUE_W-1:0] h;
    sum = tick_total + ticks;
    tick_total = (sum > 17'hFFFF) ? 16'hFFFF : sum[TICK_W-1:0];
    if (tick_total < period_cfg) return;
    tick_total = '0;
    h = hue_now % 360;
    expected_colors.push_back(paint_hue(h));
    nxt = hue_now + step_cfg;
    hue_now = (nxt >= 360) ? '0 : nxt[HUE_W-1:0];
  endfunction

  always @(posedge clk_i) begin : watch
    color_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result: hue_used %0d", hue_used_o);
          errors++;
        end else begin
          want = expected_colors.pop_front();
          if (red_compare_o !== want.red) begin
            $error("red_compare: expected %0d, actual %0d", want.red, red_compare_o);
            errors++;
          end
          if (green_compare_o !== want.green) begin
            $error("green_compare: expected %0d, actual %0d", want.green, green_compare_o);
            errors++;
          end
          if (blue_compare_o !== want.blue) begin
            $error("blue_compare: expected %0d, actual %0d", want.blue, blue_compare_o);
            errors++;
          end
          if (hue_used_o !== want.hue) begin
            $error("hue_used: expected %0d, actual %0d", want.hue, hue_used_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) advance_rainbow(ticks_elapsed_i);
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #5000000;
    $display("rainbow_hsv_to_rgb_pwm: mismatch");
    $finish;
  end

  task automatic send_ticks(input logic [TICKS_W-1:0] t);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    in_valid_i      <= 1'b1;
    ticks_elapsed_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_cfg(input rhsv_reg_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_UPDATE_PERIOD: period_cfg = data;
      REG_SATURATION:    sat_cfg    = data[PCT_W-1:0];
      REG_BRIGHTNESS:    bri_cfg    = data[PCT_W-1:0];
      default:           step_cfg   = data[HUE_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [PCT_W-1:0] pick_percent();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return PERCENT_FULL;
      2:       return PCT_W'($urandom_range(101, 127));
      default: return PCT_W'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic pick_config();
    logic [CFG_DAT_W-1:0] junk;
    logic [TICK_W-1:0]    p;
    logic [HUE_W-1:0]     st;
    junk = CFG_DAT_W'($urandom);
    case ($urandom_range(0, 7))
      0:       p = '0;
      1:       p = 16'd1;
      2:       p = TICK_W'($urandom_range(100, 400));
      3:       p = TICK_SAT;
      default: p = TICK_W'($urandom_range(2, 40));
    endcase
    st = ($urandom_range(0, 3) == 0) ? HUE_W'($urandom_range(360, 511))
                                     : HUE_W'($urandom_range(0, 359));
    write_cfg(REG_UPDATE_PERIOD, p);
    write_cfg(REG_SATURATION, {junk[CFG_DAT_W-1:PCT_W], pick_percent()});
    write_cfg(REG_BRIGHTNESS, {junk[CFG_DAT_W-1:PCT_W], pick_percent()});
    write_cfg(REG_HUE_STEP, {junk[CFG_DAT_W-1:HUE_W], st});
  endtask

  task automatic test_reset_defaults();
    logic [TICKS_W-1:0] seq[11] = '{0, 1, 2, 4, 8, 15, 15, 15, 15, 15, 15};
    foreach (seq[i]) send_ticks(seq[i]);
    drain_results();
  endtask

  task automatic test_zero_period();
    write_cfg(REG_UPDATE_PERIOD, '0);
    send_ticks(4'd0);
    send_ticks(4'd7);
    send_ticks(4'd0);
    drain_results();
  endtask

  task automatic test_hue_sectors();
    write_cfg(REG_SATURATION, 16'd100);
    write_cfg(REG_BRIGHTNESS, 16'd100);
    write_cfg(REG_HUE_STEP, 16'd50);
    repeat (8) send_ticks(4'd1);
    drain_results();
    write_cfg(REG_HUE_STEP, 16'hFFFF);
    repeat (2) send_ticks(4'd3);
    drain_results();
  endtask

  task automatic test_percent_limits();
    logic [PCT_W-1:0] sats[4] = '{0, 100, 127, 101};
    logic [PCT_W-1:0] bris[4] = '{100, 0, 127, 101};
    write_cfg(REG_HUE_STEP, 16'd97);
    foreach (sats[i]) begin
      write_cfg(REG_SATURATION, {9'h1FF, sats[i]});
      write_cfg(REG_BRIGHTNESS, {9'h155, bris[i]});
      send_ticks(4'd15);
      drain_results();
    end
  endtask

  task automatic test_poll_when_due();
    write_cfg(REG_UPDATE_PERIOD, 16'hFFFF);
    send_ticks(4'd15);
    send_ticks(4'd15);
    drain_results();
    write_cfg(REG_UPDATE_PERIOD, 16'd20);
    send_ticks(4'd0);
    drain_results();
  endtask

  task automatic test_random_phases();
    repeat (11) begin
      pick_config();
      repeat (115) send_ticks(TICKS_W'($urandom_range(0, 15)));
      drain_results();
    end
  endtask

  task automatic test_calm_tail();
    calm = 1'b1;
    write_cfg(REG_UPDATE_PERIOD, 16'd12);
    write_cfg(REG_SATURATION, 16'd64);
    write_cfg(REG_BRIGHTNESS, 16'd90);
    write_cfg(REG_HUE_STEP, 16'd13);
    repeat (150) send_ticks(TICKS_W'($urandom_range(0, 15)));
  endtask

  initial begin
    errors     = 0;
    calm       = 1'b0;
    period_cfg = PERIOD_RST;
    sat_cfg    = SAT_RST;
    bri_cfg    = BRI_RST;
    step_cfg   = STEP_RST;
    hue_now    = '0;
    tick_total = '0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= REG_UPDATE_PERIOD;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    ticks_elapsed_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_zero_period();
    test_hue_sectors();
    test_percent_limits();
    test_poll_when_due();
    test_random_phases();
    test_calm_tail();
    drain_results();
    if (errors == 0) begin
      $display("rainbow_hsv_to_rgb_pwm: match");
    end else begin
      $display("rainbow_hsv_to_rgb_pwm: mismatch");
    end
    $finish;
  end

endmodule
